@@ rtl/core/fibe_pkg.sv @@
package fibe_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_FLUX  = 2'd0;
  localparam logic [1:0] CMD_INDEX = 2'd1;
  localparam logic [1:0] CMD_EOS   = 2'd2;

  // Stream opcodes and limits of the flux encoding.
  localparam logic [7:0]  OP_ESCAPE    = 8'd255;
  localparam logic [7:0]  OP_INDEX     = 8'd1;
  localparam logic [7:0]  OP_SPACE     = 8'd2;
  localparam logic [7:0]  OP_EOS       = 8'd0;
  localparam logic [27:0] DIRECT_LIMIT = 28'd250;
  localparam logic [27:0] EXT_LIMIT    = 28'd1525;
  localparam logic [27:0] SPACE_TAIL   = 28'd249;

  localparam int MAX_BYTES = 7;
  localparam int CNT_W     = 3;

  // One classified event: the bytes it expands to and how many there are.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
  } entry_t;

endpackage

@@ rtl/core/fibe_front.sv @@
module fibe_front (
  input  logic [1:0]       command,
  input  logic [27:0]      ticks,
  output logic             keep,
  output fibe_pkg::entry_t entry
);

  logic [27:0] value;
  logic [10:0] ext_off;
  logic [2:0]  ext_quo;
  logic [10:0] ext_rem;

  // Offset of an extended interval and its split into 255-tick steps.
  always_comb begin
    ext_off = ticks[10:0] - fibe_pkg::DIRECT_LIMIT[10:0];
    if (ext_off >= 11'd1020) begin
      ext_quo = 3'd4;
      ext_rem = ext_off - 11'd1020;
    end else if (ext_off >= 11'd765) begin
      ext_quo = 3'd3;
      ext_rem = ext_off - 11'd765;
    end else if (ext_off >= 11'd510) begin
      ext_quo = 3'd2;
      ext_rem = ext_off - 11'd510;
    end else if (ext_off >= 11'd255) begin
      ext_quo = 3'd1;
      ext_rem = ext_off - 11'd255;
    end else begin
      ext_quo = 3'd0;
      ext_rem = ext_off;
    end
  end

  // Value that goes into the 28-bit packed field.
  assign value = (command == fibe_pkg::CMD_INDEX) ? ticks : ticks - fibe_pkg::SPACE_TAIL;

  // Classify the event and lay out its bytes in stream order.
  always_comb begin
    keep        = 1'b1;
    entry.bytes = '0;
    entry.count = '0;
    case (command)
      fibe_pkg::CMD_FLUX: begin
        if (ticks == 28'd0) begin
          keep = 1'b0;
        end else if (ticks < fibe_pkg::DIRECT_LIMIT) begin
          entry.bytes[0] = ticks[7:0];
          entry.count    = 3'd1;
        end else if (ticks < fibe_pkg::EXT_LIMIT) begin
          entry.bytes[0] = fibe_pkg::DIRECT_LIMIT[7:0] + {5'd0, ext_quo};
          entry.bytes[1] = ext_rem[7:0] + 8'd1;
          entry.count    = 3'd2;
        end else begin
          entry.bytes[0] = fibe_pkg::OP_ESCAPE;
          entry.bytes[1] = fibe_pkg::OP_SPACE;
          entry.bytes[2] = {value[6:0], 1'b1};
          entry.bytes[3] = {value[13:7], 1'b1};
          entry.bytes[4] = {value[20:14], 1'b1};
          entry.bytes[5] = {value[27:21], 1'b1};
          entry.bytes[6] = fibe_pkg::SPACE_TAIL[7:0];
          entry.count    = 3'd7;
        end
      end
      fibe_pkg::CMD_INDEX: begin
        entry.bytes[0] = fibe_pkg::OP_ESCAPE;
        entry.bytes[1] = fibe_pkg::OP_INDEX;
        entry.bytes[2] = {value[6:0], 1'b1};
        entry.bytes[3] = {value[13:7], 1'b1};
        entry.bytes[4] = {value[20:14], 1'b1};
        entry.bytes[5] = {value[27:21], 1'b1};
        entry.count    = 3'd6;
      end
      fibe_pkg::CMD_EOS: begin
        entry.bytes[0] = fibe_pkg::OP_EOS;
        entry.count    = 3'd1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/fibe_queue.sv @@
module fibe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/fibe_back.sv @@
module fibe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  fibe_pkg::entry_t head,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  logic [fibe_pkg::CNT_W-1:0] idx;
  logic                       load;
  logic                       at_end;

  // The output register takes the next byte whenever it is free or being drained.
  assign load   = !empty && (!m_axis_tvalid || m_axis_tready);
  assign at_end = (idx == head.count - 1'b1);
  assign pop    = load && at_end;

  // Byte index within the head entry and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load) begin
        idx <= at_end ? '0 : idx + 1'b1;
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= head.bytes[idx];
      m_axis_tlast <= at_end;
    end
  end

endmodule

@@ rtl/core/flux_interval_byte_encoder_core.sv @@
// Flux interval byte encoder.
// The input stream carries one event per transaction: tuser holds the command
// (flux interval, index pulse or end of stream) and tdata the tick count.
// The output stream carries the encoded flux stream one byte per transaction,
// with tlast marking the final byte produced by each event. Zero intervals
// and the unused command code are taken and give no bytes.
// A front stage classifies each event and lays out all its bytes
// combinationally, writing them into a small queue; the back stage reads the
// head of the queue and sends one byte per cycle through a registered output
// while the receiver is ready. An accepted event is first written into the
// queue, and the back stage then loads its first byte into the output
// register. An event gives one to seven output bytes, and while the receiver
// is ready, events giving one byte each can be taken every cycle. The single
// byte-wide output lane sets this rate.
// When the receiver stalls, the output register holds its byte, the queue
// fills and s_axis_tready falls once QUEUE_DEPTH events are waiting.
// Reset empties the queue and the output register.
module flux_interval_byte_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [27:0] ticks, [31:28] zero fill
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast
);

  localparam int ENTRY_W = $bits(fibe_pkg::entry_t);

  fibe_pkg::entry_t   front_entry;
  fibe_pkg::entry_t   head_entry;
  logic               keep;
  logic               full;
  logic               empty;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] head_bits;

  // Classification of the incoming event.
  fibe_front u_front (
    .command (s_axis_tuser),
    .ticks   (s_axis_tdata[27:0]),
    .keep    (keep),
    .entry   (front_entry)
  );

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full && keep;

  // Queue between the front and the back stage.
  fibe_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_bits),
    .empty     (empty)
  );

  assign head_entry = fibe_pkg::entry_t'(head_bits);

  // Byte serialiser and output register.
  fibe_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head_entry),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
